/* src/ihpl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihpl_pkg: shared definitions for the Intel HEX page loader
// Page geometry, record field phases, character codes and the page store
// request bundle.
// ----------------------------------------------------------------------------
package ihpl_pkg;

    localparam int PAGE_BYTES = 64;                      // power of two, 2 .. 64
    localparam int ADDR_W     = $clog2(PAGE_BYTES);      // page store index
    localparam int FILL_W     = $clog2(PAGE_BYTES + 1);  // holds PAGE_BYTES
    localparam int FADDR_W    = 16;                      // flash address width

    // Record field phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_SUM   = 3'd5;
    localparam logic [2:0] PH_ERR   = 3'd6;

    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_P      = 8'h70;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;
    localparam logic [7:0] TYPE_EOF    = 8'h01;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              clr;
    } ps_req_t;

endpackage

/* src/ihpl_page_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihpl_page_store: page buffer
// One-write, one-read byte memory with registered read data. Per-entry valid
// bits make unwritten entries read as erased flash; a clear drops them all.
// ----------------------------------------------------------------------------
module ihpl_page_store import ihpl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  ps_req_t    req,
    output logic [7:0] rd_data
);

    logic [7:0]            mem [PAGE_BYTES];
    logic [PAGE_BYTES-1:0] valid_reg;
    logic [7:0]            rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : ERASED_BYTE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.clr) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/ihpl_rem_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihpl_rem_unit: remainder of an address by the page size
// The page size is a power of two, so the remainder is the low address bits,
// captured on start; done pulses in the cycle after start.
// ----------------------------------------------------------------------------
module ihpl_rem_unit import ihpl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [FADDR_W-1:0] dividend,
    output logic               done,
    output logic [ADDR_W-1:0]  rem
);

    logic              done_reg, done_next;
    logic [ADDR_W-1:0] rem_reg, rem_next;

    always_comb begin
        done_next = start;
        rem_next  = rem_reg;
        if (start) begin
            rem_next = dividend[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* src/intel_hex_page_loader_top.sv */
`timescale 1ns / 1ps
// Input stalls: the address field of the first record after a flush waits in
// ST_BASE for the page base remainder. A page flush reads each byte through
// the single page store read port (ST_FL_RD), then emits it (ST_FL_EMIT),
// holding on output stalls; an error notice leaves via ST_ERR after its char.
// Throughput: one character per cycle outside those sequences.
// Reset (aresetn, synchronous, low): parser idle, page store reads as 0xFF.
// ----------------------------------------------------------------------------
// intel_hex_page_loader_top: Intel HEX record parser with page buffer
// Decodes HEX records after a 'p' command, packs data into a page, emits the
// page as flash byte writes when full or at the end record, and error notices.
// ----------------------------------------------------------------------------
module intel_hex_page_loader_top import ihpl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_char,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [FADDR_W-1:0] m_flash_addr,
    output logic [7:0]         m_flash_byte,
    output logic               m_file_end,
    output logic               m_last
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_BASE    = 3'd1;
    localparam logic [2:0] ST_FL_RD   = 3'd2;
    localparam logic [2:0] ST_FL_EMIT = 3'd3;
    localparam logic [2:0] ST_ERR     = 3'd4;

    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(PAGE_BYTES - 1);
    localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(PAGE_BYTES - 1);

    logic [2:0]         state_reg, state_next;
    logic               parsing_active_reg, parsing_active_next;
    logic [2:0]         field_phase_reg, field_phase_next;
    logic [2:0]         digit_count_reg, digit_count_next;
    logic [15:0]        digit_acc_reg, digit_acc_next;
    logic [7:0]         record_length_reg, record_length_next;
    logic [7:0]         record_type_reg, record_type_next;
    logic [7:0]         running_sum_reg, running_sum_next;
    logic [7:0]         data_seen_reg, data_seen_next;
    logic [FADDR_W-1:0] page_base_reg, page_base_next;
    logic               base_pending_reg, base_pending_next;
    logic [FILL_W-1:0]  fill_count_reg, fill_count_next;
    logic [ADDR_W-1:0]  flush_idx_reg, flush_idx_next;
    logic               flush_end_reg, flush_end_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_kind_reg, m_kind_next;
    logic [FADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [7:0]         m_byte_reg, m_byte_next;
    logic               m_end_reg, m_end_next;
    logic               m_last_reg, m_last_next;

    logic               s_accept;
    logic               out_free;
    logic [7:0]         digit_val;
    logic [15:0]        acc_shift;
    logic [2:0]         cnt_inc;
    logic [2:0]         need;
    logic               field_done;
    logic [7:0]         val8;
    logic [7:0]         sum_after;
    logic [7:0]         seen_inc;
    ps_req_t            st_req;
    logic [7:0]         st_rd_data;
    logic               rem_start;
    logic               rem_done;
    logic [ADDR_W-1:0]  rem_val;

    // Hex digit value; any other character enters with its raw code.
    function automatic logic [7:0] hex_value(input logic [7:0] ch);
        logic [7:0] v;
        v = ch;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            v = ch - 8'h30;
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            v = ch - 8'h37;
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            v = ch - 8'h57;
        end
        return v;
    endfunction

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign digit_val  = hex_value(s_rx_char);
    assign acc_shift  = {digit_acc_reg[11:0], 4'h0} + {8'h00, digit_val};
    assign cnt_inc    = digit_count_reg + 3'd1;
    assign need       = (field_phase_reg == PH_ADDR) ? 3'd4 : 3'd2;
    assign field_done = (cnt_inc >= need);
    assign val8       = acc_shift[7:0];
    assign sum_after  = running_sum_reg + val8;
    assign seen_inc   = data_seen_reg + 8'd1;

    ihpl_page_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (st_req),
        .rd_data (st_rd_data)
    );

    ihpl_rem_unit u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (acc_shift),
        .done     (rem_done),
        .rem      (rem_val)
    );

    always_comb begin
        state_next          = state_reg;
        parsing_active_next = parsing_active_reg;
        field_phase_next    = field_phase_reg;
        digit_count_next    = digit_count_reg;
        digit_acc_next      = digit_acc_reg;
        record_length_next  = record_length_reg;
        record_type_next    = record_type_reg;
        running_sum_next    = running_sum_reg;
        data_seen_next      = data_seen_reg;
        page_base_next      = page_base_reg;
        base_pending_next   = base_pending_reg;
        fill_count_next     = fill_count_reg;
        flush_idx_next      = flush_idx_reg;
        flush_end_next      = flush_end_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_kind_next         = m_kind_reg;
        m_addr_next         = m_addr_reg;
        m_byte_next         = m_byte_reg;
        m_end_next          = m_end_reg;
        m_last_next         = m_last_reg;
        st_req              = '0;
        rem_start           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (!parsing_active_reg) begin
                        if (s_rx_char == CHAR_P) begin
                            parsing_active_next = 1'b1;
                        end
                    end else if (field_phase_reg == PH_ERR) begin
                        state_next = ST_ERR;
                    end else if (field_phase_reg == PH_START) begin
                        if (s_rx_char == CHAR_COLON) begin
                            running_sum_next = '0;
                            field_phase_next = PH_LEN;
                            digit_count_next = '0;
                            digit_acc_next   = '0;
                        end
                    end else if (field_phase_reg <= PH_SUM) begin
                        if (!field_done) begin
                            digit_acc_next   = acc_shift;
                            digit_count_next = cnt_inc;
                        end else begin
                            digit_acc_next   = '0;
                            digit_count_next = '0;
                            unique case (field_phase_reg)
                                PH_LEN: begin
                                    record_length_next = val8;
                                    running_sum_next   = sum_after;
                                    field_phase_next   = PH_ADDR;
                                end
                                PH_ADDR: begin
                                    running_sum_next = running_sum_reg + acc_shift[7:0]
                                                       + acc_shift[15:8];
                                    if (base_pending_reg) begin
                                        // Base is aligned down once the remainder is known.
                                        page_base_next    = acc_shift;
                                        base_pending_next = 1'b0;
                                        rem_start         = 1'b1;
                                        state_next        = ST_BASE;
                                    end
                                    field_phase_next = PH_TYPE;
                                end
                                PH_TYPE: begin
                                    record_type_next = val8;
                                    running_sum_next = sum_after;
                                    data_seen_next   = '0;
                                    if (val8 == TYPE_EOF || record_length_reg == 8'd0) begin
                                        field_phase_next = PH_SUM;
                                    end else begin
                                        field_phase_next = PH_DATA;
                                    end
                                end
                                PH_DATA: begin
                                    st_req.wr_en     = 1'b1;
                                    st_req.wr_addr   = fill_count_reg[ADDR_W-1:0];
                                    st_req.wr_data   = val8;
                                    running_sum_next = sum_after;
                                    fill_count_next  = fill_count_reg + FILL_W'(1);
                                    if (seen_inc == record_length_reg) begin
                                        data_seen_next   = '0;
                                        field_phase_next = PH_SUM;
                                    end else begin
                                        data_seen_next   = seen_inc;
                                        field_phase_next = PH_DATA;
                                    end
                                    if (fill_count_reg == LAST_FILL) begin
                                        flush_end_next = 1'b0;
                                        flush_idx_next = '0;
                                        state_next     = ST_FL_RD;
                                    end
                                end
                                default: begin
                                    running_sum_next = sum_after;
                                    if (record_type_reg == TYPE_EOF) begin
                                        flush_end_next      = 1'b1;
                                        flush_idx_next      = '0;
                                        parsing_active_next = 1'b0;
                                        state_next          = ST_FL_RD;
                                    end
                                    field_phase_next = (sum_after == 8'd0) ? PH_START
                                                                           : PH_ERR;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_BASE: begin
                if (rem_done) begin
                    page_base_next = page_base_reg - FADDR_W'(rem_val);
                    state_next     = ST_IDLE;
                end
            end
            ST_FL_RD: begin
                st_req.rd_en   = 1'b1;
                st_req.rd_addr = flush_idx_reg;
                state_next     = ST_FL_EMIT;
            end
            ST_FL_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_WRITE;
                    m_addr_next  = page_base_reg + FADDR_W'(flush_idx_reg);
                    m_byte_next  = st_rd_data;
                    m_end_next   = flush_end_reg;
                    m_last_next  = (flush_idx_reg == LAST_IDX);
                    if (flush_idx_reg == LAST_IDX) begin
                        st_req.clr        = 1'b1;
                        fill_count_next   = '0;
                        base_pending_next = 1'b1;
                        state_next        = ST_IDLE;
                    end else begin
                        flush_idx_next = flush_idx_reg + ADDR_W'(1);
                        state_next     = ST_FL_RD;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_ERROR;
                    m_addr_next  = '0;
                    m_byte_next  = '0;
                    m_end_next   = 1'b0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            parsing_active_reg <= 1'b0;
            field_phase_reg    <= PH_START;
            digit_count_reg    <= '0;
            digit_acc_reg      <= '0;
            record_length_reg  <= '0;
            record_type_reg    <= '0;
            running_sum_reg    <= '0;
            data_seen_reg      <= '0;
            page_base_reg      <= '0;
            base_pending_reg   <= 1'b1;
            fill_count_reg     <= '0;
            flush_idx_reg      <= '0;
            flush_end_reg      <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            parsing_active_reg <= parsing_active_next;
            field_phase_reg    <= field_phase_next;
            digit_count_reg    <= digit_count_next;
            digit_acc_reg      <= digit_acc_next;
            record_length_reg  <= record_length_next;
            record_type_reg    <= record_type_next;
            running_sum_reg    <= running_sum_next;
            data_seen_reg      <= data_seen_next;
            page_base_reg      <= page_base_next;
            base_pending_reg   <= base_pending_next;
            fill_count_reg     <= fill_count_next;
            flush_idx_reg      <= flush_idx_next;
            flush_end_reg      <= flush_end_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg <= m_kind_next;
        m_addr_reg <= m_addr_next;
        m_byte_reg <= m_byte_next;
        m_end_reg  <= m_end_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_flash_addr = m_addr_reg;
    assign m_flash_byte = m_byte_reg;
    assign m_file_end   = m_end_reg;
    assign m_last       = m_last_reg;

    // The fill count never runs past one full page.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= FILL_W'(PAGE_BYTES))
        else $error("page fill count overran the page");

    // Error notices only come out of a parser stuck in the error phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind) |-> (field_phase_reg == PH_ERR))
        else $error("error notice without parser error");

    // The remainder unit only finishes while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rem_done |-> (state_reg == ST_BASE))
        else $error("page base remainder arrived outside base wait");

endmodule

/* tb/hex_flash_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_flash_checker: result checker for the Intel HEX page loader
// Watches both channels, decodes every accepted character in its own copy of
// the parser and page store, and compares every flash write or error notice
// with the oldest one due.
// ----------------------------------------------------------------------------
module hex_flash_checker import ihpl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_char,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_kind,
    input  logic [FADDR_W-1:0] m_flash_addr,
    input  logic [7:0]         m_flash_byte,
    input  logic               m_file_end,
    input  logic               m_last,
    output int                 fail_count,
    output int                 writes_due,
    output int                 write_count,
    output int                 notice_count
);

    typedef struct packed {
        logic               kind;
        logic [FADDR_W-1:0] addr;
        logic [7:0]         data;
        logic               file_end;
        logic               last;
    } flash_item_t;

    flash_item_t flash_writes_due[$];
    flash_item_t want;

    // Parser state
    logic               active;
    logic [2:0]         phase;
    logic [2:0]         ndigits;
    logic [15:0]        acc;
    logic [7:0]         rec_len;
    logic [7:0]         rec_type;
    logic [7:0]         byte_sum;
    logic [7:0]         data_cnt;
    logic [15:0]        page_base;
    logic               base_open;
    logic [6:0]         fill;
    logic [7:0]         page [PAGE_BYTES];

    function automatic logic [15:0] char_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 16'(c - "0");
        if (c >= "A" && c <= "F") return 16'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 16'(c - "a" + 10);
        return 16'(c);
    endfunction

    task automatic start_field(input logic [2:0] ph);
        phase   = ph;
        ndigits = '0;
        acc     = '0;
    endtask

    task automatic clear_model();
        active    = 1'b0;
        rec_len   = '0;
        rec_type  = '0;
        byte_sum  = '0;
        data_cnt  = '0;
        page_base = '0;
        base_open = 1'b1;
        fill      = '0;
        start_field(PH_START);
        for (int k = 0; k < PAGE_BYTES; k++) page[k] = ERASED_BYTE;
        flash_writes_due.delete();
    endtask

    // The whole page leaves as one run of byte writes and the store is erased.
    task automatic flush_page(input logic eof);
        flash_item_t it;
        for (int k = 0; k < PAGE_BYTES; k++) begin
            it.kind     = KIND_WRITE;
            it.addr     = page_base + 16'(k);
            it.data     = page[k];
            it.file_end = eof;
            it.last     = (k == PAGE_BYTES - 1);
            flash_writes_due.push_back(it);
            page[k] = ERASED_BYTE;
        end
        fill      = '0;
        base_open = 1'b1;
    endtask

    task automatic decode_hex_char(input logic [7:0] c);
        logic [2:0]  need;
        logic [7:0]  v;
        flash_item_t it;
        if (!active) begin
            if (c == CHAR_P) active = 1'b1;
        end else if (phase == PH_ERR) begin
            it = '{KIND_ERROR, '0, 8'h00, 1'b0, 1'b1};
            flash_writes_due.push_back(it);
        end else if (phase == PH_START) begin
            if (c == CHAR_COLON) begin
                byte_sum = '0;
                start_field(PH_LEN);
            end
        end else if (phase <= PH_SUM) begin
            acc     = acc * 16'd16 + char_value(c);
            ndigits = ndigits + 3'd1;
            need    = (phase == PH_ADDR) ? 3'd4 : 3'd2;
            if (ndigits >= need) begin
                v = acc[7:0];
                case (phase)
                    PH_LEN: begin
                        rec_len  = v;
                        byte_sum = byte_sum + v;
                        start_field(PH_ADDR);
                    end
                    PH_ADDR: begin
                        byte_sum = byte_sum + acc[7:0] + acc[15:8];
                        if (base_open) begin
                            page_base = acc - 16'(acc % PAGE_BYTES);
                            base_open = 1'b0;
                        end
                        start_field(PH_TYPE);
                    end
                    PH_TYPE: begin
                        rec_type = v;
                        byte_sum = byte_sum + v;
                        data_cnt = '0;
                        if (rec_type == TYPE_EOF || rec_len == 8'd0) start_field(PH_SUM);
                        else start_field(PH_DATA);
                    end
                    PH_DATA: begin
                        if (fill < PAGE_BYTES) page[fill] = v;
                        byte_sum = byte_sum + v;
                        fill     = fill + 7'd1;
                        data_cnt = data_cnt + 8'd1;
                        if (data_cnt == rec_len) begin
                            data_cnt = '0;
                            start_field(PH_SUM);
                        end else begin
                            start_field(PH_DATA);
                        end
                        if (fill >= PAGE_BYTES) flush_page(1'b0);
                    end
                    default: begin
                        byte_sum = byte_sum + v;
                        if (rec_type == TYPE_EOF) begin
                            flush_page(1'b1);
                            active = 1'b0;
                        end
                        start_field(byte_sum == 8'd0 ? PH_START : PH_ERR);
                    end
                endcase
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
            fail_count   = 0;
            write_count  = 0;
            notice_count = 0;
        end else begin
            if (s_valid === 1'b1 && s_ready === 1'b1) decode_hex_char(s_rx_char);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                if (flash_writes_due.size() == 0) begin
                    $display("%0t: unexpected transaction: expected none, got kind=%0b addr=%h byte=%h end=%0b last=%0b",
                             $time, m_kind, m_flash_addr, m_flash_byte, m_file_end, m_last);
                    fail_count++;
                end else begin
                    want = flash_writes_due.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_kind));
                    check_field("flash_addr", want.addr, m_flash_addr);
                    check_field("flash_byte", 16'(want.data), 16'(m_flash_byte));
                    check_field("file_end", 16'(want.file_end), 16'(m_file_end));
                    check_field("last", 16'(want.last), 16'(m_last));
                    if (want.kind == KIND_ERROR) notice_count++;
                    else write_count++;
                end
            end
        end
        writes_due = flash_writes_due.size();
    end

endmodule

/* tb/tb_intel_hex_page_loader_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_intel_hex_page_loader_top: regression bench for the Intel HEX page loader
// Feeds HEX record streams with random gaps, lets the result side stall at
// random, and relies on the checker for every comparison. A bad checksum is
// sent only at the end, since the error state lasts until reset.
// ----------------------------------------------------------------------------
module tb_intel_hex_page_loader_top;
    import ihpl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_char;
    logic               m_valid;
    logic               m_ready;
    logic               m_kind;
    logic [FADDR_W-1:0] m_flash_addr;
    logic [7:0]         m_flash_byte;
    logic               m_file_end;
    logic               m_last;

    int fail_count;
    int writes_due;
    int write_count;
    int notice_count;
    int cycles;
    int record_chars;
    int records_sent;
    int eof_sent;
    bit parsing;
    bit quiet_src;
    bit quiet_sink;

    intel_hex_page_loader_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_char    (s_rx_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_flash_addr (m_flash_addr),
        .m_flash_byte (m_flash_byte),
        .m_file_end   (m_file_end),
        .m_last       (m_last)
    );

    hex_flash_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_char    (s_rx_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_flash_addr (m_flash_addr),
        .m_flash_byte (m_flash_byte),
        .m_file_end   (m_file_end),
        .m_last       (m_last),
        .fail_count   (fail_count),
        .writes_due   (writes_due),
        .write_count  (write_count),
        .notice_count (notice_count)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [15:0] char_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 16'(c - "0");
        if (c >= "A" && c <= "F") return 16'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 16'(c - "a" + 10);
        return 16'(c);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // Characters that the block ignores while idle or between records.
    function automatic logic [7:0] idle_junk();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_P);
        return c;
    endfunction

    function automatic logic [7:0] gap_junk();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_COLON);
        return c;
    endfunction

    task automatic feed_char(input logic [7:0] c);
        int gap;
        gap = quiet_src ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_rx_char = c;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    // A noisy byte uses arbitrary characters; the value they decode to is returned.
    task automatic send_hex_byte(input logic [7:0] v, input bit noisy, output logic [7:0] got);
        logic [7:0] c1;
        logic [7:0] c2;
        bit         upper;
        if (noisy) begin
            c1 = 8'($urandom_range(0, 255));
            c2 = 8'($urandom_range(0, 255));
            got = 8'(char_value(c1) * 16'd16 + char_value(c2));
        end else begin
            upper = 1'($urandom_range(0, 1));
            c1  = hex_char(v[7:4], upper);
            c2  = hex_char(v[3:0], upper);
            got = v;
        end
        feed_char(c1);
        feed_char(c2);
        record_chars += 2;
    endtask

    task automatic send_hex_record(input int len, input logic [15:0] addr,
                                   input logic [7:0] rtype, input bit addr_noisy,
                                   input bit good);
        logic [7:0]  sum;
        logic [7:0]  got;
        logic [7:0]  c;
        logic [15:0] acc;
        sum = '0;
        feed_char(CHAR_COLON);
        record_chars++;
        send_hex_byte(8'(len), 1'b0, got);
        sum += got;
        if (addr_noisy) begin
            acc = '0;
            repeat (4) begin
                c = 8'($urandom_range(0, 255));
                feed_char(c);
                acc = acc * 16'd16 + char_value(c);
            end
            record_chars += 4;
        end else begin
            send_hex_byte(addr[15:8], 1'b0, got);
            send_hex_byte(addr[7:0], 1'b0, got);
            acc = addr;
        end
        sum += acc[7:0] + acc[15:8];
        send_hex_byte(rtype, 1'b0, got);
        sum += got;
        if (rtype != TYPE_EOF) begin
            for (int i = 0; i < len; i++) begin
                send_hex_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, got);
                sum += got;
            end
        end
        sum = 8'h00 - sum;
        if (!good) sum = sum + 8'($urandom_range(1, 255));
        send_hex_byte(sum, 1'b0, got);
        records_sent++;
        if (rtype == TYPE_EOF) begin
            eof_sent++;
            parsing = 1'b0;
        end
    endtask

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            int stall;
            stall = quiet_sink ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            @(negedge aclk);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding", cycles, writes_due);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int         len;
        int         r;
        logic [7:0] rtype;
        logic [15:0] addr;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_rx_char    = 8'h00;
        record_chars = 0;
        records_sent = 0;
        eof_sent     = 0;
        parsing      = 1'b0;
        quiet_src    = 1'b0;
        quiet_sink   = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Idle characters are dropped until the command character arrives.
        feed_char(8'h00);
        feed_char(8'hFF);
        feed_char(CHAR_COLON);
        feed_char(CHAR_P);
        parsing = 1'b1;
        feed_char(CHAR_P);
        // Zero-length record at the top of the address space, then an empty
        // end record that flushes a fully erased page.
        send_hex_record(0, 16'hFFFF, 8'h00, 1'b0, 1'b1);
        send_hex_record(0, 16'h0000, TYPE_EOF, 1'b0, 1'b1);

        while (record_chars < 340) begin
            quiet_src  = ($urandom_range(0, 3) == 0);
            quiet_sink = ($urandom_range(0, 3) == 0);
            if (!parsing) begin
                repeat ($urandom_range(0, 2)) feed_char(idle_junk());
                feed_char(CHAR_P);
                parsing = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) feed_char(gap_junk());
            r = $urandom_range(0, 19);
            if (r == 0) len = 0;
            else if (r < 14) len = $urandom_range(1, 8);
            else if (r < 18) len = $urandom_range(9, 24);
            else len = $urandom_range(25, 48);
            r = $urandom_range(0, 11);
            if (r < 2) begin
                rtype = TYPE_EOF;
                len   = $urandom_range(0, 8);
            end else if (r == 2) begin
                do rtype = 8'($urandom_range(0, 255)); while (rtype == TYPE_EOF);
            end else begin
                rtype = 8'h00;
            end
            r = $urandom_range(0, 9);
            addr = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            send_hex_record(len, addr, rtype, $urandom_range(0, 7) == 0, 1'b1);
        end

        // A bad checksum locks the parser in its error state for the rest of the run.
        quiet_src  = 1'b0;
        quiet_sink = 1'b0;
        if (!parsing) begin
            feed_char(CHAR_P);
            parsing = 1'b1;
        end
        if ($urandom_range(0, 1) == 0) begin
            send_hex_record($urandom_range(0, 4), 16'($urandom_range(0, 65535)), TYPE_EOF,
                            1'b0, 1'b0);
            feed_char(idle_junk());
            feed_char(idle_junk());
            feed_char(CHAR_P);
        end else begin
            send_hex_record($urandom_range(1, 6), 16'($urandom_range(0, 65535)), 8'h00,
                            1'b0, 1'b0);
        end
        repeat (12) begin
            feed_char(8'($urandom_range(0, 255)));
            record_chars++;
        end
        s_valid = 1'b0;

        while (writes_due != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);

        $display("Sent %0d record characters in %0d records (%0d end records) in %0d cycles.",
                 record_chars, records_sent, eof_sent, cycles);
        $display("Checked %0d flash byte writes and %0d error notices.",
                 write_count, notice_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
src/ihpl_pkg.sv
src/ihpl_page_store.sv
src/ihpl_rem_unit.sv
src/intel_hex_page_loader_top.sv
tb/hex_flash_checker.sv
tb/tb_intel_hex_page_loader_top.sv
